/* design/rdp_pkg.sv */
// Package for the render deadline profiler.
// Holds field widths, operation and register codes, controller states and
// the command and status structs shared by the controller and the datapath.
package rdp_pkg;

    // Field widths
    localparam int TS_W       = 32;
    localparam int CNT_W      = 32;
    localparam int FRAME_IN_W = 16;
    localparam int FRAME_W    = 15;
    localparam int SAMPLE_W   = 16;
    localparam int LOAD_W     = 24;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 32;

    // Stream widths
    localparam int IN_DATA_W  = TS_W + FRAME_IN_W + SAMPLE_W;
    localparam int IN_USER_W  = OP_W;
    localparam int OUT_DATA_W = 1 + 7 * CNT_W + 2 * LOAD_W + FRAME_W;

    // Default number of fraction bits of the load ratio
    localparam int LOAD_FRAC_BITS_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_END    = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CPU_CLOCK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] CPU_CLOCK_RST   = 32'd480000000;
    localparam logic [CFG_W-1:0] SAMPLE_RATE_RST = 32'd48000;

    // Sample codes that count as clipped
    localparam logic [SAMPLE_W-1:0] CLIP_POS_FULL = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] CLIP_NEG_SYM  = 16'h8001;
    localparam logic [SAMPLE_W-1:0] CLIP_NEG_FULL = 16'h8000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic commit;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* design/render_deadline_profiler_unit.sv */
// Top level of the render deadline profiler.
// Depends on rdp_pkg, rdp_ctrl, rdp_datapath and rdp_divider.
//
// The profiler handles one request at a time and returns one result for each
// request: a snapshot of all counters after the request is applied. A begin
// that opens a window and an end that closes one with a nonzero budget go
// through the shared serial divider, which yields one quotient bit per cycle
// over max(47, 32 + LOAD_FRAC_BITS) bits. Such a request steps through
// capture, dispatch, divider start, division, commit and emit; all others
// skip the divider steps. The emit step waits until the output register is
// free. A new request is accepted while the previous result still waits in
// the output register. Configuration writes are taken in every cycle and
// should be issued only while no request is in flight.
module render_deadline_profiler_unit
    import rdp_pkg::*;
#(
    parameter int LOAD_FRAC_BITS = LOAD_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: timestamp[31:0], frame_count[47:32], sample[63:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: busy_res[0], cycle_budget[32:1], last_elapsed[64:33],
    // max_elapsed[96:65], renders_done[128:97], deadline_misses[160:129],
    // reentries[192:161], clipped_samples[224:193], last_load_q16[248:225],
    // peak_load_q16[272:249], frames_in_block[287:273]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    rdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // State, arithmetic and output register
    rdp_datapath #(
        .LOAD_FRAC_BITS (LOAD_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* design/rdp_divider.sv */
// Serial restoring divider of the render deadline profiler.
// Produces one quotient bit per cycle; uses rdp_pkg for the divisor width.
module rdp_divider
    import rdp_pkg::*;
#(
    parameter int DVD_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [CFG_W-1:0]  i_divisor,
    output logic [DVD_W-1:0]  o_quotient,
    output logic              o_done
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_acc;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CFG_W:0]    rem_sh;
    logic [CFG_W:0]    rem_sub;
    logic              q_bit;

    // One trial subtraction of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_acc[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Step counter and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_step <= STEP_W'(DVD_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
        end
    end

    assign o_quotient = r_acc;
    assign o_done     = r_done;

endmodule

/* design/rdp_datapath.sv */
// Datapath of the render deadline profiler: configuration, profile state,
// budget multiplier, divider operands and the output register.
// Depends on rdp_pkg and rdp_divider.
module rdp_datapath
    import rdp_pkg::*;
#(
    parameter int LOAD_FRAC_BITS = LOAD_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [IN_DATA_W-1:0]   i_in_data,
    input  logic [IN_USER_W-1:0]   i_in_user,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_DATA_W-1:0]  o_out_data
);

    localparam int PROD_W = FRAME_W + CFG_W;
    localparam int LOAD_DVD_W = TS_W + LOAD_FRAC_BITS;
    localparam int DVD_W = (PROD_W > LOAD_DVD_W) ? PROD_W : LOAD_DVD_W;

    // Configuration registers
    logic [CFG_W-1:0] r_cpu_clock;
    logic [CFG_W-1:0] r_sample_rate;

    // Latched request
    logic [OP_W-1:0]       r_op;
    logic [TS_W-1:0]       r_stamp;
    logic [FRAME_IN_W-1:0] r_frames_raw;
    logic [SAMPLE_W-1:0]   r_sample;

    // Profile state
    logic               r_in_window;
    logic [TS_W-1:0]    r_begin_stamp;
    logic [CNT_W-1:0]   r_budget;
    logic [FRAME_W-1:0] r_block_frames;
    logic [TS_W-1:0]    r_elapsed_last;
    logic [TS_W-1:0]    r_elapsed_max;
    logic [CNT_W-1:0]   r_render_cnt;
    logic [CNT_W-1:0]   r_miss_cnt;
    logic [CNT_W-1:0]   r_reentry_cnt;
    logic [CNT_W-1:0]   r_clip_cnt;
    logic [LOAD_W-1:0]  r_load_last;
    logic [LOAD_W-1:0]  r_load_peak;

    // Divider operands and elapsed time of the closing window
    logic [DVD_W-1:0]   r_dvd;
    logic [CFG_W-1:0]   r_dvs;
    logic [TS_W-1:0]    r_elapsed;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [FRAME_W-1:0] frames_clamped;
    logic [PROD_W-1:0]  product;
    logic [CFG_W-1:0]   rate_eff;
    logic [TS_W-1:0]    elapsed_now;
    logic               begin_open;
    logic               end_open;
    logic               is_clip;
    logic [DVD_W-1:0]   quotient;
    logic               div_done;
    logic [LOAD_W-1:0]  load_sat;

    // Decode of the latched request
    always_comb begin
        frames_clamped = r_frames_raw[FRAME_IN_W-1] ? '0 : r_frames_raw[FRAME_W-1:0];
        product        = PROD_W'(frames_clamped) * PROD_W'(r_cpu_clock);
        rate_eff       = (r_sample_rate == '0) ? CFG_W'(1) : r_sample_rate;
        elapsed_now    = r_stamp - r_begin_stamp;
        begin_open     = (r_op == OP_BEGIN) && !r_in_window;
        end_open       = (r_op == OP_END) && r_in_window;
        is_clip        = (r_sample == CLIP_POS_FULL) || (r_sample == CLIP_NEG_SYM)
                      || (r_sample == CLIP_NEG_FULL);
        load_sat       = (|quotient[DVD_W-1:LOAD_W]) ? '1 : quotient[LOAD_W-1:0];
    end

    assign o_status.need_div = begin_open || (end_open && (r_budget != '0));
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Shared serial divider for budget and load ratio
    rdp_divider #(
        .DVD_W (DVD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_clock   <= CPU_CLOCK_RST;
            r_sample_rate <= SAMPLE_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CPU_CLOCK:   r_cpu_clock   <= i_cfg_data;
                REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture and divider operand setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= i_in_user;
            r_stamp      <= i_in_data[TS_W-1:0];
            r_frames_raw <= i_in_data[TS_W+FRAME_IN_W-1:TS_W];
            r_sample     <= i_in_data[IN_DATA_W-1:TS_W+FRAME_IN_W];
        end
        if (i_cmd.prep) begin
            r_elapsed <= elapsed_now;
            if (begin_open) begin
                r_dvd <= DVD_W'(product);
                r_dvs <= rate_eff;
            end else begin
                r_dvd <= DVD_W'(elapsed_now) << LOAD_FRAC_BITS;
                r_dvs <= r_budget;
            end
        end
    end

    // Profile state update for the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_window    <= 1'b0;
            r_begin_stamp  <= '0;
            r_budget       <= '0;
            r_block_frames <= '0;
            r_elapsed_last <= '0;
            r_elapsed_max  <= '0;
            r_render_cnt   <= '0;
            r_miss_cnt     <= '0;
            r_reentry_cnt  <= '0;
            r_clip_cnt     <= '0;
            r_load_last    <= '0;
            r_load_peak    <= '0;
        end else if (i_cmd.commit) begin
            case (r_op)
                OP_BEGIN: begin
                    if (r_in_window) begin
                        r_reentry_cnt <= r_reentry_cnt + CNT_W'(1);
                    end else begin
                        r_in_window    <= 1'b1;
                        r_begin_stamp  <= r_stamp;
                        r_budget       <= quotient[CNT_W-1:0];
                        r_block_frames <= frames_clamped;
                    end
                end
                OP_END: begin
                    if (r_in_window) begin
                        r_in_window    <= 1'b0;
                        r_elapsed_last <= r_elapsed;
                        r_render_cnt   <= r_render_cnt + CNT_W'(1);
                        if (r_elapsed > r_elapsed_max) begin
                            r_elapsed_max <= r_elapsed;
                        end
                        if (r_budget != '0) begin
                            r_load_last <= load_sat;
                            if (load_sat > r_load_peak) begin
                                r_load_peak <= load_sat;
                            end
                            if (r_elapsed >= r_budget) begin
                                r_miss_cnt <= r_miss_cnt + CNT_W'(1);
                            end
                        end else begin
                            r_load_last <= '0;
                        end
                    end
                end
                OP_SAMPLE: begin
                    if (is_clip) begin
                        r_clip_cnt <= r_clip_cnt + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Snapshot of the state after the request, first field in the lowest bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {r_block_frames, r_load_peak, r_load_last, r_clip_cnt,
                           r_reentry_cnt, r_miss_cnt, r_render_cnt, r_elapsed_max,
                           r_elapsed_last, r_budget, r_in_window};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The maximum elapsed time never falls below the last one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed_max >= r_elapsed_last)
        else $error("maximum elapsed time below last elapsed time");

    // The peak load never falls below the last load.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_peak >= r_load_last)
        else $error("peak load below last load");

    // The render count moves only when a window closes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_render_cnt != $past(r_render_cnt)) |-> $fell(r_in_window))
        else $error("render count changed without a window closing");

endmodule

/* design/rdp_ctrl.sv */
// Controller state machine of the render deadline profiler.
// Sequences capture, operand setup, division, commit and output; uses rdp_pkg.
module rdp_ctrl
    import rdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.need_div ? ST_DIV_GO : ST_COMMIT;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A commit follows either the dispatch step or a finished division.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |->
            ($past(r_state) == ST_DISPATCH) || $past(i_status.div_done))
        else $error("commit without dispatch or finished division");

    // Every request that is taken is followed by the dispatch step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DISPATCH))
        else $error("accepted request not dispatched");

    // A result is loaded only from the emit step and leads back to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_IDLE))
        else $error("result emitted outside the emit step");

endmodule

/* verif/tb_render_deadline_profiler_unit.sv */
// Self-checking testbench for render_deadline_profiler_unit.
// Needs rdp_pkg and the profiler RTL. A class predicts the counter snapshot that
// follows every request and checks each result against it, in request order.
module tb_render_deadline_profiler_unit
    import rdp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOAD_FRAC = LOAD_FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One result, laid out like m_axis_tdata (busy in bit 0, frames on top)
    typedef struct packed {
        logic [FRAME_W-1:0] frames;
        logic [LOAD_W-1:0]  load_peak;
        logic [LOAD_W-1:0]  load_last;
        logic [CNT_W-1:0]   clips;
        logic [CNT_W-1:0]   reentries;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   renders;
        logic [CNT_W-1:0]   max_elapsed;
        logic [CNT_W-1:0]   last_elapsed;
        logic [CNT_W-1:0]   budget;
        logic               busy;
    } t_snapshot;

    // Profiler state model and the queue of snapshots still owed by the block
    class deadline_scoreboard;
        bit [CFG_W-1:0]     cpu_hz = CPU_CLOCK_RST;
        bit [CFG_W-1:0]     rate_hz = SAMPLE_RATE_RST;
        bit                 in_window;
        bit [TS_W-1:0]      start_stamp;
        bit [CNT_W-1:0]     budget;
        bit [FRAME_W-1:0]   frames;
        bit [CNT_W-1:0]     last_el, max_el, renders, misses, reentries, clips;
        bit [LOAD_W-1:0]    load_now, load_top;
        t_snapshot          owed[$];
        int unsigned        requests, results, errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_CPU_CLOCK:   cpu_hz = val;
                REG_SAMPLE_RATE: rate_hz = val;
                default: ;
            endcase
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endfunction

        function void cmp(string name, logic [CNT_W-1:0] exp, logic [CNT_W-1:0] act);
            if (exp !== act) begin
                flag($sformatf("result %0d %s expected %0h got %0h", results, name, exp, act));
            end
        endfunction

        // Apply one accepted request and record the snapshot it must produce
        function void note_request(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
            logic [TS_W-1:0]       ts;
            logic [FRAME_IN_W-1:0] fc;
            logic [SAMPLE_W-1:0]   smp;
            bit [63:0]             f, r, q, ld;
            bit [CNT_W-1:0]        el;
            t_snapshot             s;
            ts = data[31:0];
            fc = data[47:32];
            smp = data[63:48];
            requests++;
            case (op)
                OP_BEGIN: begin
                    if (in_window) begin
                        reentries++;
                    end else begin
                        // Negative frame counts clamp to zero; a zero rate acts as one
                        f = fc[15] ? 64'd0 : 64'(fc[14:0]);
                        r = (rate_hz == 0) ? 64'd1 : 64'(rate_hz);
                        q = (f * 64'(cpu_hz)) / r;
                        frames = f[FRAME_W-1:0];
                        budget = q[31:0];
                        start_stamp = ts;
                        in_window = 1'b1;
                    end
                end
                OP_END: begin
                    if (in_window) begin
                        in_window = 1'b0;
                        el = ts - start_stamp;
                        last_el = el;
                        if (el > max_el) max_el = el;
                        renders++;
                        if (budget != 0) begin
                            ld = (64'(el) << LOAD_FRAC) / 64'(budget);
                            if (ld > 64'hFF_FFFF) ld = 64'hFF_FFFF;
                            load_now = ld[LOAD_W-1:0];
                            if (load_now > load_top) load_top = load_now;
                            if (el >= budget) misses++;
                        end else begin
                            load_now = '0;
                        end
                    end
                end
                OP_SAMPLE: begin
                    if (smp == 16'h7FFF || smp == 16'h8001 || smp == 16'h8000) clips++;
                end
                default: ;
            endcase
            s = '{frames: frames, load_peak: load_top, load_last: load_now, clips: clips,
                  reentries: reentries, misses: misses, renders: renders,
                  max_elapsed: max_el, last_elapsed: last_el, budget: budget,
                  busy: in_window};
            owed.push_back(s);
        endfunction

        // Compare one result with the oldest owed snapshot
        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_snapshot got, exp;
            got = data;
            results++;
            if (owed.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing outstanding", results));
                return;
            end
            exp = owed.pop_front();
            cmp("busy", CNT_W'(exp.busy), CNT_W'(got.busy));
            cmp("budget", exp.budget, got.budget);
            cmp("last_elapsed", exp.last_elapsed, got.last_elapsed);
            cmp("max_elapsed", exp.max_elapsed, got.max_elapsed);
            cmp("renders", exp.renders, got.renders);
            cmp("misses", exp.misses, got.misses);
            cmp("reentries", exp.reentries, got.reentries);
            cmp("clips", exp.clips, got.clips);
            cmp("load_last", CNT_W'(exp.load_last), CNT_W'(got.load_last));
            cmp("load_peak", CNT_W'(exp.load_peak), CNT_W'(got.load_peak));
            cmp("frames", CNT_W'(exp.frames), CNT_W'(got.frames));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    deadline_scoreboard sb = new();
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        rx_hold = 1'b0;
    int unsigned stall_cycles = 0;
    event        holdoff_go;

    render_deadline_profiler_unit #(
        .LOAD_FRAC_BITS(LOAD_FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: random backpressure, or a solid hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering requests
    always begin
        @(holdoff_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_render_deadline_profiler_unit NOT OK");
            $finish;
        end
    end

    // Offer one request, idling first at random, and wait for its acceptance
    task automatic send(logic [OP_W-1:0] op, logic [TS_W-1:0] ts,
                        logic [FRAME_IN_W-1:0] fc, logic [SAMPLE_W-1:0] smp);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {smp, fc, ts};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, {smp, fc, ts});
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // Write both rate registers back to back while the block is idle
    task automatic set_rates(logic [CFG_W-1:0] cpu, logic [CFG_W-1:0] rate);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_CPU_CLOCK;
        i_cfg_data <= cpu;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(REG_CPU_CLOCK, cpu);
        i_cfg_index <= REG_SAMPLE_RATE;
        i_cfg_data <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(REG_SAMPLE_RATE, rate);
        i_cfg_valid <= 1'b0;
    endtask

    // One render window: begin, maybe a reentry, a few samples, then end
    task automatic play_render(ref int unsigned sent);
        logic [FRAME_IN_W-1:0] fc;
        logic [SAMPLE_W-1:0]   smp;
        logic [CNT_W-1:0]      el;
        case ($urandom_range(9))
            0:       fc = FRAME_IN_W'(-$urandom_range(1, 32768));
            1:       fc = 16'h7FFF;
            2, 3:    fc = FRAME_IN_W'($urandom_range(0, 32767));
            default: fc = FRAME_IN_W'($urandom_range(1, 1024));
        endcase
        send(OP_BEGIN, $urandom(), fc, SAMPLE_W'($urandom()));
        sent++;
        if ($urandom_range(9) == 0) begin
            send(OP_BEGIN, $urandom(), FRAME_IN_W'($urandom()), SAMPLE_W'($urandom()));
            sent++;
        end
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(5))
                0:       smp = 16'h7FFF;
                1:       smp = 16'h8001;
                2:       smp = 16'h8000;
                default: smp = SAMPLE_W'($urandom());
            endcase
            send(OP_SAMPLE, $urandom(), FRAME_IN_W'($urandom()), smp);
            sent++;
        end
        // Elapsed time chosen around the budget so both hits and misses occur
        case ($urandom_range(5))
            0:       el = $urandom();
            1:       el = sb.budget - $urandom_range(0, 64);
            2:       el = sb.budget + $urandom_range(0, 64);
            3:       el = sb.budget >> 1;
            4:       el = sb.budget;
            default: el = $urandom_range(0, 4096);
        endcase
        send(OP_END, sb.start_stamp + el, FRAME_IN_W'($urandom()), SAMPLE_W'($urandom()));
        sent++;
    endtask

    // Mostly well-formed render windows, with some random noise requests
    task automatic run_mix(int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                send(OP_W'($urandom_range(3)), $urandom(), FRAME_IN_W'($urandom()),
                     SAMPLE_W'($urandom()));
                sent++;
            end else begin
                play_render(sent);
            end
        end
    endtask

    initial begin
        tx_idle_pct = 29;
        rx_idle_pct = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clip codes and their neighbors
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h7FFF);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h8001);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h8000);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h8002);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h7FFE);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h0000);
        // End with no window open, and the unused operation
        send(OP_END, 32'h1234, 16'd0, 16'd0);
        send(OP_UNUSED, '1, '1, '1);
        // Normal window with a reentry and a sample inside it
        send(OP_BEGIN, 32'd1000, 16'd256, 16'd0);
        send(OP_BEGIN, 32'd5, 16'd7, 16'd0);
        send(OP_SAMPLE, 32'd0, 16'd0, 16'h8000);
        send(OP_END, 32'd1500, 16'd0, 16'd0);
        // Negative frames give a zero budget and a zero load
        send(OP_BEGIN, 32'd0, -16'sd5, 16'd0);
        send(OP_END, 32'd77, 16'd0, 16'd0);
        // Largest frame count, timestamps wrapping through zero
        send(OP_BEGIN, 32'hFFFF_FFF0, 16'h7FFF, 16'd0);
        send(OP_END, 32'h0000_0010, 16'd0, 16'd0);
        // Elapsed exactly on budget, then far past it with a saturated load
        send(OP_BEGIN, 32'd0, 16'd1, 16'd0);
        send(OP_END, 32'd10000, 16'd0, 16'd0);
        send(OP_BEGIN, 32'd0, 16'd1, 16'd0);
        send(OP_END, 32'hFFFF_FFFF, 16'd0, 16'd0);
        // Most negative frame count and a zero elapsed time
        send(OP_BEGIN, 32'd9, 16'h8000, 16'hFFFF);
        send(OP_END, 32'd9, 16'd0, 16'd0);

        // Random phases over several rate settings
        run_mix(250);
        set_rates(32'hFFFF_FFFF, 32'd0);
        run_mix(150);

        tx_idle_pct = 61;
        rx_idle_pct = 29;
        set_rates(32'd0, 32'hFFFF_FFFF);
        run_mix(100);
        set_rates($urandom(), $urandom_range(1, 200000));
        run_mix(100);
        -> holdoff_go;
        run_mix(200);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_rates(32'd1, 32'd1);
        run_mix(100);
        set_rates(CPU_CLOCK_RST, SAMPLE_RATE_RST);
        run_mix(300);

        // Let everything outstanding come back, then allow for late extras
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.owed.size() != 0) begin
            sb.flag($sformatf("%0d results never arrived", sb.owed.size()));
        end

        $display("Ran %0d requests over six rate settings, %0d results checked.",
                 sb.requests, sb.results);
        $display("Model saw %0d renders, %0d misses, %0d reentries, %0d clipped samples.",
                 sb.renders, sb.misses, sb.reentries, sb.clips);
        if (sb.errors == 0) begin
            $display("tb_render_deadline_profiler_unit OK");
        end else begin
            $display("tb_render_deadline_profiler_unit NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rdp_pkg.sv
design/rdp_divider.sv
design/rdp_datapath.sv
design/rdp_ctrl.sv
design/render_deadline_profiler_unit.sv
verif/tb_render_deadline_profiler_unit.sv
